/* rtl/core/caldate_pkg.sv */
// Types, codes and month tables for the Gregorian date counter.
// No dependencies; imported by calendar_date_counter.
`default_nettype none

package caldate_pkg;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_BACK    = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // Year held as century and year within century, so leap tests need no divider
    typedef struct packed {
        logic [6:0] cent;
        logic [6:0] yy;
        logic [3:0] month;
        logic [4:0] day;
        logic [8:0] doy;
    } t_date;

    localparam logic [13:0] YEAR_MAX       = 14'd9999;
    localparam logic [6:0]  CENT_MAX       = 7'd99;
    localparam logic [6:0]  YY_MAX         = 7'd99;
    localparam logic [13:0] YEARS_PER_CENT = 14'd100;
    localparam logic [3:0]  MONTH_FIRST    = 4'd1;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_LAST     = 4'd12;
    localparam logic [4:0]  DAY_FIRST      = 5'd1;
    localparam logic [4:0]  DAY_LAST_DEC   = 5'd31;
    localparam logic [8:0]  DAYS_PLAIN     = 9'd365;
    // Reciprocal of 100 for years below 10000: q = (y * 5243) >> 19
    localparam logic [12:0] CENT_RECIP     = 13'd5243;
    localparam int          CENT_SHIFT     = 19;
    localparam logic [6:0]  RESET_CENT     = 7'd19;
    localparam logic [6:0]  RESET_YY       = 7'd0;

    function automatic logic f_is_leap(input logic [6:0] cent, input logic [6:0] yy);
        logic leap;
        if (yy == 7'd0) begin
            leap = (cent[1:0] == 2'd0);
        end else begin
            leap = (yy[1:0] == 2'd0);
        end
        return leap;
    endfunction

    function automatic logic [4:0] f_days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month == MONTH_FEB) begin
            len = 5'd28 + {4'd0, leap};
        end else if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    // Days in the months before this one, common year
    function automatic logic [8:0] f_days_before(input logic [3:0] month);
        logic [8:0] sum;
        case (month)
            4'd1:    sum = 9'd0;
            4'd2:    sum = 9'd31;
            4'd3:    sum = 9'd59;
            4'd4:    sum = 9'd90;
            4'd5:    sum = 9'd120;
            4'd6:    sum = 9'd151;
            4'd7:    sum = 9'd181;
            4'd8:    sum = 9'd212;
            4'd9:    sum = 9'd243;
            4'd10:   sum = 9'd273;
            4'd11:   sum = 9'd304;
            4'd12:   sum = 9'd334;
            default: sum = 9'd0;
        endcase
        return sum;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/calendar_date_counter.sv */
// Load passes S_SPLIT, S_REM, S_LOAD; back S_BACK; advance by n days loops in S_STEP (n limited
// to MAX_STEP); unused opcode goes to S_DONE at once. Results are registered in S_DONE.
// Throughput: one item at a time; advance walks one day per cycle through the day-step unit.
// Reset (synchronous, active low) sets the date to 1900-01-01, day of year 1, and empties
// the result register.
// Depends on caldate_pkg.
`default_nettype none

module calendar_date_counter #(
    parameter int unsigned MAX_STEP = 1023
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [13:0] i_load_year,
    input  wire logic [3:0]  i_load_month,
    input  wire logic [4:0]  i_load_day,
    input  wire logic [9:0]  i_step_count,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [13:0]      o_year_out,
    output logic [3:0]       o_month_out,
    output logic [4:0]       o_day_out,
    output logic [8:0]       o_day_of_year,
    output logic             o_leap_flag
);

    import caldate_pkg::*;

    // The step field is 10 bits, so a cap above 1023 never bites
    localparam int unsigned StepCap  = (MAX_STEP < 1023) ? MAX_STEP : 1023;
    localparam logic [9:0]  StepCapW = 10'(StepCap);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_REM,
        S_LOAD,
        S_STEP,
        S_BACK,
        S_DONE
    } t_state;

    t_state      r_state;
    t_date       r_date;
    t_date       n_date;
    logic [9:0]  r_steps;
    logic [13:0] r_ld_year;
    logic [3:0]  r_ld_month;
    logic [4:0]  r_ld_day;
    logic        r_out_valid;

    logic        w_leap;
    logic [4:0]  w_dim;
    logic        w_back;
    logic [26:0] w_prod;
    logic [13:0] w_rem;
    logic [4:0]  w_ld_lim;
    logic [4:0]  w_ld_day;
    logic [6:0]  w_prev_cent;
    logic [6:0]  w_prev_yy;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign w_leap = f_is_leap(r_date.cent, r_date.yy);
    assign w_dim  = f_days_in(r_date.month, w_leap);
    assign w_back = (r_state == S_BACK);

    // Load path: century by reciprocal multiply, then remainder, then day clamp
    assign w_prod   = 27'(r_ld_year) * 27'(CENT_RECIP);
    assign w_rem    = r_ld_year - (14'(r_date.cent) * YEARS_PER_CENT);
    assign w_ld_lim = f_days_in(r_ld_month, w_leap);

    always_comb begin
        if (r_ld_day == 5'd0) begin
            w_ld_day = DAY_FIRST;
        end else if (r_ld_day > w_ld_lim) begin
            w_ld_day = w_ld_lim;
        end else begin
            w_ld_day = r_ld_day;
        end
    end

    // Year before the current one, for stepping back across New Year
    always_comb begin
        if (r_date.yy == 7'd0) begin
            w_prev_cent = r_date.cent - 7'd1;
            w_prev_yy   = YY_MAX;
        end else begin
            w_prev_cent = r_date.cent;
            w_prev_yy   = r_date.yy - 7'd1;
        end
    end

    // Shared day-step unit: one day forward, or one back in S_BACK.
    // Day of year moves by one except across New Year; both ends of the range hold.
    always_comb begin
        n_date = r_date;
        if (w_back) begin
            if (r_date.day > DAY_FIRST) begin
                n_date.day = r_date.day - 5'd1;
                n_date.doy = r_date.doy - 9'd1;
            end else if (r_date.month > MONTH_FIRST) begin
                n_date.month = r_date.month - 4'd1;
                n_date.day   = f_days_in(r_date.month - 4'd1, w_leap);
                n_date.doy   = r_date.doy - 9'd1;
            end else if ((r_date.cent != 7'd0) || (r_date.yy != 7'd0)) begin
                n_date.cent  = w_prev_cent;
                n_date.yy    = w_prev_yy;
                n_date.month = MONTH_LAST;
                n_date.day   = DAY_LAST_DEC;
                n_date.doy   = DAYS_PLAIN + {8'd0, f_is_leap(w_prev_cent, w_prev_yy)};
            end
        end else begin
            if (r_date.day < w_dim) begin
                n_date.day = r_date.day + 5'd1;
                n_date.doy = r_date.doy + 9'd1;
            end else if (r_date.month < MONTH_LAST) begin
                n_date.month = r_date.month + 4'd1;
                n_date.day   = DAY_FIRST;
                n_date.doy   = r_date.doy + 9'd1;
            end else if ((r_date.cent != CENT_MAX) || (r_date.yy != YY_MAX)) begin
                if (r_date.yy == YY_MAX) begin
                    n_date.cent = r_date.cent + 7'd1;
                    n_date.yy   = 7'd0;
                end else begin
                    n_date.yy   = r_date.yy + 7'd1;
                end
                n_date.month = MONTH_FIRST;
                n_date.day   = DAY_FIRST;
                n_date.doy   = 9'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_date      <= '{cent: RESET_CENT, yy: RESET_YY, month: MONTH_FIRST,
                             day: DAY_FIRST, doy: 9'd1};
        end else begin
            // Drop the result once the sink has taken the beat, unless a new one replaces it
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (t_opcode'(i_opcode))
                            OP_LOAD: begin
                                // Saturate the raw fields now; the day waits for the leap test
                                r_ld_year  <= (i_load_year > YEAR_MAX) ? YEAR_MAX : i_load_year;
                                if (i_load_month < MONTH_FIRST) begin
                                    r_ld_month <= MONTH_FIRST;
                                end else if (i_load_month > MONTH_LAST) begin
                                    r_ld_month <= MONTH_LAST;
                                end else begin
                                    r_ld_month <= i_load_month;
                                end
                                r_ld_day <= i_load_day;
                                r_state  <= S_SPLIT;
                            end
                            OP_ADVANCE: begin
                                r_steps <= (i_step_count > StepCapW) ? StepCapW : i_step_count;
                                r_state <= S_STEP;
                            end
                            OP_BACK: begin
                                r_state <= S_BACK;
                            end
                            default: begin
                                // Unused opcode: report the date unchanged
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SPLIT: begin
                    r_date.cent <= w_prod[CENT_SHIFT +: 7];
                    r_state     <= S_REM;
                end
                S_REM: begin
                    r_date.yy <= w_rem[6:0];
                    r_state   <= S_LOAD;
                end
                S_LOAD: begin
                    r_date.month <= r_ld_month;
                    r_date.day   <= w_ld_day;
                    r_date.doy   <= f_days_before(r_ld_month) + {4'd0, w_ld_day}
                                    + {8'd0, (r_ld_month > MONTH_FEB) && w_leap};
                    r_state      <= S_DONE;
                end
                S_STEP: begin
                    // Advance one day per cycle until the count runs out
                    if (r_steps == 10'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_date  <= n_date;
                        r_steps <= r_steps - 10'd1;
                    end
                end
                S_BACK: begin
                    r_date  <= n_date;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold here while the previous result has not been taken
                    if (!r_out_valid || i_out_ready) begin
                        o_year_out    <= (14'(r_date.cent) * YEARS_PER_CENT) + 14'(r_date.yy);
                        o_month_out   <= r_date.month;
                        o_day_out     <= r_date.day;
                        o_day_of_year <= r_date.doy;
                        o_leap_flag   <= w_leap;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
